@@ rtl/core/mfmid_pkg.sv @@
// Package for the MFM sector ID field generator.
// Holds the channel payload types, the command passed from front to back,
// register indexes, reset values and the CRC-16-CCITT byte update.
package mfmid_pkg;

    // Widths of the configuration write port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 13;

    // Default values of the top-level parameters.
    localparam int DEF_MAX_SECTORS     = 32;
    localparam int DEF_MAX_TRACK       = 85;
    localparam int DEF_INTERLEAVE_STEP = 6;

    // One request never yields more than this many ID fields.
    localparam int RESULT_LIMIT = 32;

    // Track length that enables interleaved numbering.
    localparam int INTERLEAVE_SECTORS = 11;

    // Sector sizes with their own size codes.
    localparam logic [12:0] BYTES_128  = 13'd128;
    localparam logic [12:0] BYTES_256  = 13'd256;
    localparam logic [12:0] BYTES_1024 = 13'd1024;

    localparam logic [1:0] SIZE_CODE_128  = 2'd0;
    localparam logic [1:0] SIZE_CODE_256  = 2'd1;
    localparam logic [1:0] SIZE_CODE_512  = 2'd2;
    localparam logic [1:0] SIZE_CODE_1024 = 2'd3;

    // Configuration register indexes.
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SIDE_COUNT       = 3'd0,
        REG_TRACKS_PER_SIDE  = 3'd1,
        REG_SECTORS_PER_TRK  = 3'd2,
        REG_FORMATTED_SECTS  = 3'd3,
        REG_BYTES_PER_SECTOR = 3'd4,
        REG_INTERLEAVE_EN    = 3'd5
    } cfg_reg_t;

    // Register values after reset.
    localparam logic [1:0]  RST_SIDE_COUNT       = 2'd2;
    localparam logic [7:0]  RST_TRACKS_PER_SIDE  = 8'd80;
    localparam logic [5:0]  RST_SECTORS_PER_TRK  = 6'd9;
    localparam logic [5:0]  RST_FORMATTED_SECTS  = 6'd9;
    localparam logic [12:0] RST_BYTES_PER_SECTOR = 13'd512;
    localparam logic        RST_INTERLEAVE_EN    = 1'b0;

    // Input item.
    typedef struct packed {
        logic       side;
        logic [7:0] track;
        logic       track_reformatted;
        logic       disk_present;
    } in_t;

    // Result item.
    typedef struct packed {
        logic        valid_res;
        logic [7:0]  id_track;
        logic        id_side;
        logic [5:0]  sector_number;
        logic [1:0]  size_code;
        logic [15:0] id_crc;
        logic        last;
    } out_t;

    // Classified request handed from the front to the back.
    typedef struct packed {
        logic        ok;
        logic        side;
        logic [7:0]  track;
        logic [5:0]  count;
        logic [1:0]  size_code;
        logic        interleave;
        logic [15:0] crc_base;
    } cmd_t;

    // CRC-16-CCITT, polynomial 0x1021, one byte MSB first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0] data);
        logic [15:0] c;
        int          i;
        c = crc_in ^ {data, 8'h00};
        for (i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ 16'h1021;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    // CRC after the fixed A1 A1 A1 FE lead-in, worked out at elaboration.
    localparam logic [15:0] CRC_PREFIX =
        crc_byte(crc_byte(crc_byte(crc_byte(16'hFFFF, 8'hA1), 8'hA1), 8'hA1), 8'hFE);

endpackage

@@ rtl/core/mfmid_front.sv @@
// Front part of the MFM sector ID field generator: configuration registers,
// request acceptance, range checks and the track/side part of the CRC.
// Depends on mfmid_pkg.
module mfmid_front #(
    parameter int MAX_SECTORS = mfmid_pkg::DEF_MAX_SECTORS,
    parameter int MAX_TRACK   = mfmid_pkg::DEF_MAX_TRACK
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  mfmid_pkg::in_t                       s_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mfmid_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [mfmid_pkg::CFG_DATA_W-1:0]     cfg_data,
    output logic                                 q_push,
    input  logic                                 q_ready,
    output mfmid_pkg::cmd_t                      q_cmd
);
    import mfmid_pkg::*;

    localparam int CNT_LIMIT = (MAX_SECTORS < RESULT_LIMIT) ? MAX_SECTORS : RESULT_LIMIT;

    typedef enum logic [2:0] {
        F_IDLE = 3'b001,
        F_CALC = 3'b010,
        F_PUSH = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [1:0]  side_count_reg;
    logic [7:0]  tracks_per_side_reg;
    logic [5:0]  sectors_per_trk_reg;
    logic [5:0]  formatted_sects_reg;
    logic [12:0] bytes_per_sector_reg;
    logic        interleave_en_reg;

    in_t         req_reg;
    logic        ok_reg;
    logic [5:0]  count_reg;
    logic [15:0] crc_trk_reg;

    logic        fmt;
    logic [1:0]  side_lim;
    logic [8:0]  track_lim;
    logic [5:0]  cnt_raw;
    logic [5:0]  cnt_sat;
    logic        req_ok;
    logic [1:0]  size_code;

    // Configuration writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_count_reg       <= RST_SIDE_COUNT;
            tracks_per_side_reg  <= RST_TRACKS_PER_SIDE;
            sectors_per_trk_reg  <= RST_SECTORS_PER_TRK;
            formatted_sects_reg  <= RST_FORMATTED_SECTS;
            bytes_per_sector_reg <= RST_BYTES_PER_SECTOR;
            interleave_en_reg    <= RST_INTERLEAVE_EN;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SIDE_COUNT:       side_count_reg       <= cfg_data[1:0];
                REG_TRACKS_PER_SIDE:  tracks_per_side_reg  <= cfg_data[7:0];
                REG_SECTORS_PER_TRK:  sectors_per_trk_reg  <= cfg_data[5:0];
                REG_FORMATTED_SECTS:  formatted_sects_reg  <= cfg_data[5:0];
                REG_BYTES_PER_SECTOR: bytes_per_sector_reg <= cfg_data;
                REG_INTERLEAVE_EN:    interleave_en_reg    <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Limits of the requested track: reformatted tracks up to MAX_TRACK use the format limits.
    always_comb begin
        fmt       = req_reg.track_reformatted && (req_reg.track <= 8'(MAX_TRACK));
        side_lim  = fmt ? 2'd2 : side_count_reg;
        track_lim = fmt ? 9'(MAX_TRACK + 1) : {1'b0, tracks_per_side_reg};
        cnt_raw   = fmt ? formatted_sects_reg : sectors_per_trk_reg;
        cnt_sat   = (cnt_raw > 6'(CNT_LIMIT)) ? 6'(CNT_LIMIT) : cnt_raw;
        req_ok    = req_reg.disk_present && ({1'b0, req_reg.side} < side_lim) &&
                    ({1'b0, req_reg.track} < track_lim) && (cnt_sat != 6'd0);
    end

    // Size code of the configured sector length.
    always_comb begin
        if (bytes_per_sector_reg == BYTES_128) begin
            size_code = SIZE_CODE_128;
        end else if (bytes_per_sector_reg == BYTES_256) begin
            size_code = SIZE_CODE_256;
        end else if (bytes_per_sector_reg == BYTES_1024) begin
            size_code = SIZE_CODE_1024;
        end else begin
            size_code = SIZE_CODE_512;
        end
    end

    // Sequencer: take a request, check it, then hand it to the queue.
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            F_IDLE: if (s_valid) state_next = F_CALC;
            F_CALC: state_next = F_PUSH;
            F_PUSH: if (q_ready) state_next = F_IDLE;
            default: state_next = F_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Request payload and the classification results.
    always_ff @(posedge aclk) begin
        if (state_reg == F_IDLE && s_valid) begin
            req_reg <= s_data;
        end
        if (state_reg == F_CALC) begin
            ok_reg      <= req_ok;
            count_reg   <= cnt_sat;
            crc_trk_reg <= crc_byte(CRC_PREFIX, req_reg.track);
        end
    end

    assign s_ready = (state_reg == F_IDLE);
    assign q_push  = (state_reg == F_PUSH);

    // The side byte finishes the per-request part of the CRC.
    always_comb begin
        q_cmd.ok         = ok_reg;
        q_cmd.side       = req_reg.side;
        q_cmd.track      = req_reg.track;
        q_cmd.count      = count_reg;
        q_cmd.size_code  = size_code;
        q_cmd.interleave = interleave_en_reg &&
                           (sectors_per_trk_reg == 6'(INTERLEAVE_SECTORS));
        q_cmd.crc_base   = crc_byte(crc_trk_reg, {7'd0, req_reg.side});
    end

    // A classified request never claims more fields than one request may give.
    a_count_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (q_cmd.count <= 6'(CNT_LIMIT)))
        else $error("front: sector count above limit");

    // A request is only accepted while nothing is pending in the front.
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == F_CALC))
        else $error("front: accepted request not classified next");

    // A push to the queue always follows the classification state.
    a_push_order: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(q_push) |-> $past(state_reg == F_CALC))
        else $error("front: push without classification");

endmodule

@@ rtl/core/mfmid_cmdq.sv @@
// Two-entry command queue between the front and back of the MFM ID generator.
// Depends on mfmid_pkg.
module mfmid_cmdq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push_valid,
    output logic             push_ready,
    input  mfmid_pkg::cmd_t  push_cmd,
    output logic             pop_valid,
    input  logic             pop_ready,
    output mfmid_pkg::cmd_t  pop_cmd
);
    import mfmid_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] fill_reg, fill_next;
    logic       do_push;
    logic       do_pop;

    assign push_ready = (fill_reg != 2'd2);
    assign pop_valid  = (fill_reg != 2'd0);
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;
    assign pop_cmd    = entry_reg[rd_ptr_reg];

    // Pointer and fill count update.
    always_comb begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        fill_next   = fill_reg + {1'b0, do_push} - {1'b0, do_pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // Entry storage.
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // An empty or full queue always has equal read and write pointers.
    a_fill_ptr: assert property (@(posedge aclk) disable iff (!aresetn)
        (fill_reg == 2'd0 || fill_reg == 2'd2) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("cmdq: fill count disagrees with pointers");

    // The fill count never passes the depth.
    a_fill_max: assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= 2'd2)
        else $error("cmdq: overflow");

    // A pop with a push leaves the fill count alone.
    a_fill_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (do_push && do_pop) |=> $stable(fill_reg))
        else $error("cmdq: fill count moved on push with pop");

endmodule

@@ rtl/core/mfmid_back.sv @@
// Back part of the MFM sector ID field generator: walks the sectors of one
// classified request and finishes each field's CRC over two stages.
// Depends on mfmid_pkg.
module mfmid_back #(
    parameter int INTERLEAVE_STEP = mfmid_pkg::DEF_INTERLEAVE_STEP
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_ready,
    input  mfmid_pkg::cmd_t  q_cmd,
    output logic             m_valid,
    input  logic             m_ready,
    output mfmid_pkg::out_t  m_data
);
    import mfmid_pkg::*;

    logic        active_reg, active_next;
    cmd_t        cmd_reg;
    logic [5:0]  n_reg, n_next;
    logic [3:0]  resid_reg, resid_next;

    logic        s1_valid_reg, s1_valid_next;
    out_t        s1_reg;
    logic [15:0] s1_crc_reg;

    logic        out_valid_reg, out_valid_next;
    out_t        out_reg;
    out_t        s1_done;

    logic        out_free;
    logic        s1_free;
    logic        gen;
    logic        gen_last;
    logic [5:0]  gen_num;
    logic [4:0]  resid_sum;

    assign out_free = !out_valid_reg || m_ready;
    assign s1_free  = !s1_valid_reg || out_free;
    assign gen      = active_reg && s1_free;
    assign q_ready  = !active_reg;

    // Sector number and end of the current request.
    always_comb begin
        gen_num   = cmd_reg.interleave ? (6'(resid_reg) + 6'd1) : (n_reg + 6'd1);
        gen_last  = !cmd_reg.ok || ((n_reg + 6'd1) == cmd_reg.count);
        resid_sum = 5'(resid_reg) + 5'(INTERLEAVE_STEP);
    end

    // Sector walk: n counts fields, resid is n times the step modulo eleven.
    always_comb begin
        active_next = active_reg;
        n_next      = n_reg;
        resid_next  = resid_reg;
        if (!active_reg) begin
            if (q_valid) begin
                active_next = 1'b1;
                n_next      = 6'd0;
                resid_next  = 4'd0;
            end
        end else if (gen) begin
            n_next = n_reg + 6'd1;
            if (resid_sum >= 5'(INTERLEAVE_SECTORS)) begin
                resid_next = 4'(resid_sum - 5'(INTERLEAVE_SECTORS));
            end else begin
                resid_next = resid_sum[3:0];
            end
            if (gen_last) begin
                active_next = 1'b0;
            end
        end
    end

    // Two result stages: the first adds the sector byte, the second the size byte.
    always_comb begin
        s1_valid_next  = s1_free ? gen : s1_valid_reg;
        out_valid_next = out_free ? s1_valid_reg : out_valid_reg;
    end

    // Finished field: the size byte closes the CRC of a real ID field.
    always_comb begin
        s1_done        = s1_reg;
        s1_done.id_crc = s1_reg.valid_res ?
                         crc_byte(s1_crc_reg, {6'd0, s1_reg.size_code}) : 16'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg    <= 1'b0;
            n_reg         <= 6'd0;
            resid_reg     <= 4'd0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            active_reg    <= active_next;
            n_reg         <= n_next;
            resid_reg     <= resid_next;
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        if (q_valid && q_ready) begin
            cmd_reg <= q_cmd;
        end
        if (gen) begin
            s1_reg.valid_res     <= cmd_reg.ok;
            s1_reg.id_track      <= cmd_reg.ok ? cmd_reg.track : 8'd0;
            s1_reg.id_side       <= cmd_reg.ok && cmd_reg.side;
            s1_reg.sector_number <= cmd_reg.ok ? gen_num : 6'd0;
            s1_reg.size_code     <= cmd_reg.ok ? cmd_reg.size_code : 2'd0;
            s1_reg.id_crc        <= 16'd0;
            s1_reg.last          <= gen_last;
            s1_crc_reg           <= crc_byte(cmd_reg.crc_base, {2'd0, gen_num});
        end
        if (out_free && s1_valid_reg) begin
            out_reg <= s1_done;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // An invalid result is always the only and final one of its request.
    a_invalid_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.valid_res) |-> m_data.last)
        else $error("back: invalid result not marked last");

    // Real ID fields carry a one-based sector number.
    a_sector_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.valid_res) |-> (m_data.sector_number != 6'd0))
        else $error("back: zero sector number");

    // The walk ends on the field marked last.
    a_last_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        (gen && gen_last) |=> !active_reg)
        else $error("back: walk continues past last field");

endmodule

@@ rtl/core/mfm_sector_id_field_generator.sv @@
// Top level of the MFM sector ID field generator: front (checks, CRC lead-in),
// command queue and back (sector walk, CRC finish). Depends on mfmid_pkg.
//
//   channel   direction  handshake              payload
//   s_        in         s_valid / s_ready      s_data   (in_t: one request)
//   m_        out        m_valid / m_ready      m_data   (out_t: one ID field)
//   cfg_      in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// The front steps each request through accept, check and push (the CRC over the
// side byte is formed as it is pushed); the back then emits one ID field per
// cycle while m_ready is high, after a load step for each command, and the
// front overlaps with the previous track's fields.
// Results leave through a registered output, behind the first result stage.
// Reset is synchronous and needs no clearing pass; cfg_ready is always high.
module mfm_sector_id_field_generator #(
    parameter int MAX_SECTORS     = mfmid_pkg::DEF_MAX_SECTORS,
    parameter int MAX_TRACK       = mfmid_pkg::DEF_MAX_TRACK,
    parameter int INTERLEAVE_STEP = mfmid_pkg::DEF_INTERLEAVE_STEP
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  mfmid_pkg::in_t                    s_data,
    output logic                              m_valid,
    input  logic                              m_ready,
    output mfmid_pkg::out_t                   m_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [mfmid_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [mfmid_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import mfmid_pkg::*;

    logic push_valid;
    logic push_ready;
    cmd_t push_cmd;
    logic pop_valid;
    logic pop_ready;
    cmd_t pop_cmd;

    // Request checks and per-request CRC part.
    mfmid_front #(
        .MAX_SECTORS (MAX_SECTORS),
        .MAX_TRACK   (MAX_TRACK)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_push    (push_valid),
        .q_ready   (push_ready),
        .q_cmd     (push_cmd)
    );

    // Decoupling queue.
    mfmid_cmdq u_cmdq (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_cmd    (pop_cmd)
    );

    // Sector walk and result output.
    mfmid_back #(
        .INTERLEAVE_STEP (INTERLEAVE_STEP)
    ) u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (pop_valid),
        .q_ready (pop_ready),
        .q_cmd   (pop_cmd),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

@@ dv/mfmid_tb_pkg.sv @@
// Scoreboard for the MFM sector ID field generator testbench.
// Predicts the ID fields of each request from a shadow of the registers and
// checks every result transfer against them. Depends on mfmid_pkg.
package mfmid_tb_pkg;

    import mfmid_pkg::*;

    // Fixed bytes and CRC settings of an ID field.
    localparam logic [7:0]  SYNC_MARK  = 8'hA1;
    localparam logic [7:0]  ID_MARK    = 8'hFE;
    localparam logic [15:0] CRC_SEED   = 16'hFFFF;
    localparam logic [15:0] CCITT_POLY = 16'h1021;

    class id_field_tracker;

        // Shadow copy of the configuration registers.
        logic [1:0]  side_count;
        logic [7:0]  tracks_per_side;
        logic [5:0]  sectors_per_track;
        logic [5:0]  formatted_sectors;
        logic [12:0] bytes_per_sector;
        logic        interleave_en;

        // ID fields still owed by the block, oldest first.
        out_t        expected_fields[$];
        int          failures;

        function new();
            side_count        = RST_SIDE_COUNT;
            tracks_per_side   = RST_TRACKS_PER_SIDE;
            sectors_per_track = RST_SECTORS_PER_TRK;
            formatted_sectors = RST_FORMATTED_SECTS;
            bytes_per_sector  = RST_BYTES_PER_SECTOR;
            interleave_en     = RST_INTERLEAVE_EN;
            failures          = 0;
        endfunction

        function void write_register(cfg_reg_t idx, logic [CFG_DATA_W-1:0] value);
            case (idx)
                REG_SIDE_COUNT:       side_count        = value[1:0];
                REG_TRACKS_PER_SIDE:  tracks_per_side   = value[7:0];
                REG_SECTORS_PER_TRK:  sectors_per_track = value[5:0];
                REG_FORMATTED_SECTS:  formatted_sectors = value[5:0];
                REG_BYTES_PER_SECTOR: bytes_per_sector  = value;
                REG_INTERLEAVE_EN:    interleave_en     = value[0];
                default: ;
            endcase
        endfunction

        // Bitwise CRC-16-CCITT update, most significant bit first.
        static function logic [15:0] crc16_step(logic [15:0] crc, logic [7:0] data);
            logic [15:0] c;
            logic        fb;
            c = crc;
            for (int i = 7; i >= 0; i--) begin
                fb = c[15] ^ data[i];
                c  = {c[14:0], 1'b0};
                if (fb) begin
                    c = c ^ CCITT_POLY;
                end
            end
            return c;
        endfunction

        // Works out the ID fields that one accepted request must produce.
        function void predict_id_fields(in_t req);
            logic        fmt;
            int          side_lim;
            int          track_lim;
            int          count;
            logic [1:0]  code;
            logic [7:0]  num;
            logic [15:0] crc;
            logic [7:0]  id_bytes[8];
            out_t        f;

            fmt       = req.track_reformatted && (int'(req.track) <= DEF_MAX_TRACK);
            side_lim  = fmt ? 2 : int'(side_count);
            track_lim = fmt ? DEF_MAX_TRACK + 1 : int'(tracks_per_side);
            count     = fmt ? int'(formatted_sectors) : int'(sectors_per_track);
            if (count > DEF_MAX_SECTORS) count = DEF_MAX_SECTORS;
            if (count > RESULT_LIMIT) count = RESULT_LIMIT;

            case (bytes_per_sector)
                BYTES_128:  code = SIZE_CODE_128;
                BYTES_256:  code = SIZE_CODE_256;
                BYTES_1024: code = SIZE_CODE_1024;
                default:    code = SIZE_CODE_512;
            endcase

            // Empty drive, side or track out of range, or no sectors: one blank field.
            if (!req.disk_present || int'(req.side) >= side_lim ||
                int'(req.track) >= track_lim || count == 0) begin
                f      = '0;
                f.last = 1'b1;
                expected_fields.push_back(f);
                return;
            end

            for (int n = 0; n < count; n++) begin
                // Interleave is decided by the ordinary track length, even on
                // a reformatted track.
                if (interleave_en && int'(sectors_per_track) == INTERLEAVE_SECTORS) begin
                    num = 8'(1 + (n * DEF_INTERLEAVE_STEP) % INTERLEAVE_SECTORS);
                end else begin
                    num = 8'(n + 1);
                end
                id_bytes = '{SYNC_MARK, SYNC_MARK, SYNC_MARK, ID_MARK,
                             req.track, {7'b0, req.side}, num, {6'b0, code}};
                crc = CRC_SEED;
                foreach (id_bytes[b]) begin
                    crc = crc16_step(crc, id_bytes[b]);
                end
                f.valid_res     = 1'b1;
                f.id_track      = req.track;
                f.id_side       = req.side;
                f.sector_number = num[5:0];
                f.size_code     = code;
                f.id_crc        = crc;
                f.last          = (n + 1 == count);
                expected_fields.push_back(f);
            end
        endfunction

        function void compare(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $error("%s: expected %0h, got %0h", field, want, got);
                failures++;
            end
        endfunction

        // Checks one result transfer against the oldest owed ID field.
        function void check_field(out_t got);
            out_t want;
            if (expected_fields.size() == 0) begin
                $error("ID field %h arrived with none expected", got);
                failures++;
                return;
            end
            want = expected_fields.pop_front();
            compare("valid_res", want.valid_res, got.valid_res);
            compare("id_track", want.id_track, got.id_track);
            compare("id_side", want.id_side, got.id_side);
            compare("sector_number", want.sector_number, got.sector_number);
            compare("size_code", want.size_code, got.size_code);
            compare("id_crc", want.id_crc, got.id_crc);
            compare("last", want.last, got.last);
        endfunction

    endclass

endpackage

@@ dv/testbench.sv @@
// Top of the MFM sector ID field generator testbench: clock, reset, request
// and register drivers, result sink and run control.
// Depends on mfmid_pkg, mfmid_tb_pkg and the generator RTL.
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    import mfmid_pkg::*;
    import mfmid_tb_pkg::*;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 300;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    in_t                   s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    out_t                  m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    id_field_tracker tracker = new();

    // Run control shared with the result sink.
    bit steady       = 1'b0;
    int hold_asks    = 0;
    int holds_served = 0;
    int hold_left    = 0;
    int cycle_count  = 0;

    always #4 aclk = ~aclk;

    mfm_sector_id_field_generator uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Result sink: checks each transfer, then picks ready for the next cycle.
    // A hold-off request from the stimulus keeps ready low for a long stretch.
    always @(posedge aclk) begin
        if (m_valid && m_ready) begin
            tracker.check_field(m_data);
        end
        if (holds_served != hold_asks) begin
            holds_served = hold_asks;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else if (steady) begin
            m_ready <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= 16);
        end
    end

    // Guard against a hung block.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Offers one request after a random idle stretch and waits for its transfer.
    task automatic send_request(input in_t req);
        if (!steady) begin
            while ($urandom_range(0, 99) < 16) begin
                s_valid <= 1'b0;
                @(posedge aclk);
            end
        end
        s_valid <= 1'b1;
        s_data  <= req;
        do @(posedge aclk); while (!s_ready);
        tracker.predict_id_fields(req);
    endtask

    // Stops offering and waits until every owed ID field has come out.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (tracker.expected_fields.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic put_register(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        tracker.write_register(idx, value);
    endtask

    // Writes all six registers back to back; only called with the block idle.
    task automatic configure(input int sides, input int tracks, input int spt,
                             input int fsc, input int bytes, input int il);
        put_register(REG_SIDE_COUNT, CFG_DATA_W'(sides));
        put_register(REG_TRACKS_PER_SIDE, CFG_DATA_W'(tracks));
        put_register(REG_SECTORS_PER_TRK, CFG_DATA_W'(spt));
        put_register(REG_FORMATTED_SECTS, CFG_DATA_W'(fsc));
        put_register(REG_BYTES_PER_SECTOR, CFG_DATA_W'(bytes));
        put_register(REG_INTERLEAVE_EN, CFG_DATA_W'(il));
        cfg_valid <= 1'b0;
    endtask

    // Mostly short tracks, with eleven often enough to exercise interleave.
    function automatic int pick_sectors();
        int pct;
        pct = $urandom_range(0, 99);
        if (pct < 25) return INTERLEAVE_SECTORS;
        if (pct < 85) return $urandom_range(1, 12);
        if (pct < 93) return $urandom_range(0, 63);
        return RESULT_LIMIT;
    endfunction

    // Mostly well-formed requests for the current layout, some noise.
    function automatic in_t random_request();
        in_t r;
        int  track_hi;
        r.disk_present      = ($urandom_range(0, 99) >= 8);
        r.side              = 1'($urandom_range(0, 1));
        r.track_reformatted = ($urandom_range(0, 99) < 30);
        if (r.track_reformatted) begin
            track_hi = DEF_MAX_TRACK;
        end else begin
            track_hi = (tracker.tracks_per_side == 0) ? 0 : int'(tracker.tracks_per_side) - 1;
        end
        if ($urandom_range(0, 99) < 75) begin
            r.track = 8'($urandom_range(0, track_hi));
        end else begin
            r.track = 8'($urandom_range(0, 255));
        end
        return r;
    endfunction

    initial begin : stimulus
        int sides;
        int tracks;
        int bytes;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Request fields in order: side, track, reformatted, disk present.
        // Reset layout: two sides, 80 tracks, nine sectors.
        send_request(in_t'{1'b0, 8'd0, 1'b0, 1'b0});     // empty drive
        send_request(in_t'{1'b0, 8'd0, 1'b0, 1'b1});
        send_request(in_t'{1'b1, 8'd79, 1'b0, 1'b1});    // last track
        send_request(in_t'{1'b1, 8'd80, 1'b0, 1'b1});    // one past the last track
        send_request(in_t'{1'b0, 8'd255, 1'b0, 1'b1});
        send_request(in_t'{1'b1, 8'd85, 1'b1, 1'b1});    // highest reformatted track
        send_request(in_t'{1'b0, 8'd86, 1'b1, 1'b1});    // too high to count as reformatted

        // One side, interleaved eleven-sector tracks, empty format count.
        wait_drained();
        configure(1, 255, 11, 0, 128, 1);
        send_request(in_t'{1'b1, 8'd10, 1'b0, 1'b1});    // side out of range
        send_request(in_t'{1'b0, 8'd254, 1'b0, 1'b1});
        send_request(in_t'{1'b0, 8'd255, 1'b0, 1'b1});
        send_request(in_t'{1'b1, 8'd50, 1'b1, 1'b1});    // reformatted with no sectors
        send_request(in_t'{1'b0, 8'd200, 1'b1, 1'b1});

        // Empty image layout and an oversized format count that saturates.
        wait_drained();
        configure(0, 0, 0, 63, 1024, 1);
        send_request(in_t'{1'b0, 8'd0, 1'b0, 1'b1});
        send_request(in_t'{1'b1, 8'd85, 1'b1, 1'b1});
        send_request(in_t'{1'b0, 8'd0, 1'b1, 1'b0});

        // Full-length ordinary track and sequential reformatted numbering.
        wait_drained();
        configure(3, 1, 32, 11, 256, 0);
        send_request(in_t'{1'b1, 8'd0, 1'b0, 1'b1});
        send_request(in_t'{1'b0, 8'd1, 1'b0, 1'b1});
        send_request(in_t'{1'b0, 8'd42, 1'b1, 1'b1});

        // Interleave applied to a full reformatted track; odd sector size.
        wait_drained();
        configure(2, 86, 11, 32, 8191, 1);
        send_request(in_t'{1'b1, 8'd85, 1'b1, 1'b1});
        send_request(in_t'{1'b0, 8'd85, 1'b0, 1'b1});

        // Eleven formatted sectors but a twelve-sector layout: no interleave.
        wait_drained();
        configure(2, 255, 12, 11, 0, 1);
        send_request(in_t'{1'b1, 8'd170, 1'b0, 1'b1});
        send_request(in_t'{1'b0, 8'd170, 1'b1, 1'b1});
        send_request(in_t'{1'b1, 8'd85, 1'b1, 1'b1});

        // Random layouts, each followed by a burst of requests.
        for (int phase = 0; phase < 6; phase++) begin
            wait_drained();
            sides  = ($urandom_range(0, 99) < 70) ? 2 : $urandom_range(0, 3);
            tracks = ($urandom_range(0, 99) < 60) ? $urandom_range(40, 86)
                                                  : $urandom_range(0, 255);
            case ($urandom_range(0, 4))
                0:       bytes = BYTES_128;
                1:       bytes = BYTES_256;
                2:       bytes = 512;
                3:       bytes = BYTES_1024;
                default: bytes = $urandom_range(0, 8191);
            endcase
            configure(sides, tracks, pick_sectors(), pick_sectors(), bytes,
                      ($urandom_range(0, 99) < 60));

            // One phase runs with no idling on either side.
            steady <= (phase == 2);
            // One phase stalls the sink long enough for the block to back up.
            if (phase == 4) begin
                hold_asks <= hold_asks + 1;
            end

            for (int k = 0; k < 21; k++) begin
                send_request(random_request());
                // Mid-phase pause until the block has emptied.
                if (phase == 1 && k == 12) begin
                    wait_drained();
                end
            end
        end

        wait_drained();
        if (tracker.failures == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
